FILE: hw/rtl/ues_pkg.sv
// Shared types and constants for the unique entry stack.
package ues_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [0:0] {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_POPPED    = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    // Shift control broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

FILE: hw/rtl/ues_cell.sv
// One storage cell of the stack chain: holds an entry, shifts and compares.
module ues_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  ues_pkg::shift_ctrl_t        ctrl,
    input  logic [ues_pkg::DATA_W-1:0]  above_data,
    input  logic [ues_pkg::DATA_W-1:0]  below_data,
    input  logic [ues_pkg::DATA_W-1:0]  probe,
    input  logic [CNT_W-1:0]            fill,
    output logic [ues_pkg::DATA_W-1:0]  entry,
    output logic                        match
);

    logic [ues_pkg::DATA_W-1:0] entry_reg;
    logic [ues_pkg::DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctrl.push)
        begin
            entry_next = above_data;
        end
        else if (ctrl.pop)
        begin
            entry_next = below_data;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Match only while this position is occupied (below the fill level) and holds the probe
    assign match = (CNT_W'(INDEX) < fill) && (entry_reg == probe);
    assign entry = entry_reg;

endmodule

FILE: hw/rtl/unique_entry_stack.sv
// Top level of the unique entry stack: a chain of cells with a parallel duplicate search.
// The result of a transaction appears in the result register in the cycle after it is accepted.
// Throughput: one push or pop per cycle while the result side does not stall; the compare
// across all cells and the OR of their match lines set the cycle.
// Reset clears the fill level and the result valid flag; stored entries stay undefined
// until pushed and are never read before that.
module unique_entry_stack #(
    parameter int DEPTH = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic signed [ues_pkg::DATA_W-1:0]  value,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ues_pkg::STATUS_W-1:0]       status,
    output logic signed [ues_pkg::DATA_W-1:0]  popped_value,
    output logic [ues_pkg::COUNT_W-1:0]        entry_count,
    output logic                               is_empty,
    output logic                               is_full
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fill level: number of occupied cells; cell 0 holds the top of stack
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    // Result register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    ues_pkg::status_t              status_reg;
    ues_pkg::status_t              status_next;
    logic [ues_pkg::DATA_W-1:0]    popped_reg;
    logic [ues_pkg::DATA_W-1:0]    popped_next;
    logic [CNT_W-1:0]              count_reg;
    logic                          empty_reg;
    logic                          full_reg;

    logic                          accept;
    logic                          stack_full;
    logic                          stack_empty;
    logic                          duplicate;
    ues_pkg::shift_ctrl_t          ctrl;

    logic [ues_pkg::DATA_W-1:0]    cell_entry [DEPTH];
    logic [DEPTH-1:0]              cell_match;

    // Hold the input while a finished result waits to be taken
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign stack_full  = (fill_reg == CNT_W'(DEPTH));
    assign stack_empty = (fill_reg == '0);
    assign duplicate   = |cell_match;

    // Decide the operation; the full check takes precedence over the duplicate search
    always_comb
    begin
        ctrl        = '0;
        fill_next   = fill_reg;
        status_next = status_reg;
        popped_next = '0;
        if (cmd == ues_pkg::CMD_PUSH)
        begin
            priority if (stack_full)
            begin
                status_next = ues_pkg::ST_FULL;
            end
            else if (duplicate)
            begin
                status_next = ues_pkg::ST_DUPLICATE;
            end
            else
            begin
                status_next = ues_pkg::ST_PUSHED;
                ctrl.push   = accept;
                fill_next   = fill_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (stack_empty)
            begin
                status_next = ues_pkg::ST_EMPTY;
            end
            else
            begin
                status_next = ues_pkg::ST_POPPED;
                popped_next = cell_entry[0];
                ctrl.pop    = accept;
                fill_next   = fill_reg - CNT_W'(1);
            end
        end
    end

    // Result valid: set on acceptance, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // Result payload: capture on acceptance only
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            popped_reg <= popped_next;
            count_reg  <= fill_next;
            empty_reg  <= (fill_next == '0);
            full_reg   <= (fill_next == CNT_W'(DEPTH));
        end
    end

    // Chain of cells: push shifts every entry one cell down, pop one cell up
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ues_pkg::DATA_W-1:0] above;
        logic [ues_pkg::DATA_W-1:0] below;

        if (i == 0)
        begin : g_top
            assign above = value;
        end
        else
        begin : g_inner_above
            assign above = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign below = '0;
        end
        else
        begin : g_inner_below
            assign below = cell_entry[i+1];
        end

        ues_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .above_data (above),
            .below_data (below),
            .probe      (value),
            .fill       (fill_reg),
            .entry      (cell_entry[i]),
            .match      (cell_match[i])
        );
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = ues_pkg::COUNT_W'(count_reg);
    assign is_empty     = empty_reg;
    assign is_full      = full_reg;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the unique entry stack: directed and random pushes and pops.
module tb;
    import ues_pkg::*;

    localparam int DEPTH = 64;

    // Result fields as the block reports them for one transaction
    typedef struct packed {
        status_t                 st;
        logic [DATA_W-1:0]       popped;
        logic [COUNT_W-1:0]      count;
        logic                    empty;
        logic                    full;
    } stack_result_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      cmd          = CMD_PUSH;
    logic signed [DATA_W-1:0]  value        = '0;
    logic                      out_stall    = 1'b0;
    logic                      in_stall;
    logic                      out_valid;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  popped_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    logic                      is_full;

    // Mirror of the stack contents, bottom entry at index 0
    logic [DATA_W-1:0]         stack_mirror [DEPTH];
    int                        mirror_level = 0;
    stack_result_t             expected_results [$];
    int                        fail_count   = 0;
    // When set, the sender issues back-to-back transactions with no gaps
    bit                        sender_quiet = 1'b0;

    unique_entry_stack #(.DEPTH(DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    always #4 clk = ~clk;

    // Idle length: mostly none or short, now and then a long pause
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic bit holds_value(input logic [DATA_W-1:0] v);
        for (int i = 0; i < mirror_level; i++)
        begin
            if (stack_mirror[i] == v)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one operation to the mirror and return the result it must produce;
    // the full check takes precedence over the duplicate search
    function automatic stack_result_t apply_stack_op(input cmd_t op,
                                                     input logic [DATA_W-1:0] v);
        stack_result_t r;
        r.popped = '0;
        if (op == CMD_PUSH)
        begin
            if (mirror_level >= DEPTH)
                r.st = ST_FULL;
            else if (holds_value(v))
                r.st = ST_DUPLICATE;
            else
            begin
                stack_mirror[mirror_level] = v;
                mirror_level++;
                r.st = ST_PUSHED;
            end
        end
        else if (mirror_level == 0)
            r.st = ST_EMPTY;
        else
        begin
            mirror_level--;
            r.popped = stack_mirror[mirror_level];
            r.st = ST_POPPED;
        end
        r.count = mirror_level[COUNT_W-1:0];
        r.empty = (mirror_level == 0);
        r.full  = (mirror_level == DEPTH);
        return r;
    endfunction

    // Present one transaction, hold it until accepted, then record its outcome
    task automatic send_op(input cmd_t op, input logic [DATA_W-1:0] v);
        int gap;
        in_valid <= 1'b1;
        cmd      <= op;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_stack_op(op, v));
        gap = sender_quiet ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] fresh_value();
        logic [DATA_W-1:0] v;
        do
            v = $urandom();
        while (holds_value(v));
        return v;
    endfunction

    // Push candidate: often a stored entry, sometimes a small value from a narrow
    // pool so that collisions also arise naturally, otherwise any pattern
    function automatic logic [DATA_W-1:0] push_candidate();
        int                r;
        logic [DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 35 && mirror_level > 0)
            v = stack_mirror[$urandom_range(0, mirror_level - 1)];
        else if (r < 55)
        begin
            v = DATA_W'($urandom_range(0, 15));
            if ($urandom_range(0, 1))
                v = ~v;
        end
        else
            v = $urandom();
        return v;
    endfunction

    // Empty stack, extreme values and duplicates at top, middle and bottom
    task automatic test_extremes_and_duplicates();
        send_op(CMD_POP, 32'hDEAD_BEEF);
        send_op(CMD_PUSH, 32'h8000_0000);
        send_op(CMD_PUSH, 32'h7FFF_FFFF);
        send_op(CMD_PUSH, 32'h0000_0000);
        send_op(CMD_PUSH, 32'hFFFF_FFFF);
        send_op(CMD_PUSH, 32'h5555_5555);
        send_op(CMD_PUSH, 32'hAAAA_AAAA);
        send_op(CMD_PUSH, 32'hAAAA_AAAA);
        send_op(CMD_PUSH, 32'h7FFF_FFFF);
        send_op(CMD_PUSH, 32'h8000_0000);
        repeat (6) send_op(CMD_POP, 32'hFFFF_FFFF);
        send_op(CMD_POP, 32'h0000_0000);
        // a value popped earlier must be accepted again
        send_op(CMD_PUSH, 32'h0000_0000);
        send_op(CMD_POP, 32'h1234_5678);
    endtask

    // Fill to capacity, then check that full outranks duplicate, and drain
    task automatic test_fill_to_full();
        while (mirror_level < DEPTH)
            send_op(CMD_PUSH, fresh_value());
        send_op(CMD_PUSH, fresh_value());
        send_op(CMD_PUSH, stack_mirror[0]);
        send_op(CMD_PUSH, stack_mirror[DEPTH - 1]);
        send_op(CMD_POP, $urandom());
        send_op(CMD_PUSH, stack_mirror[DEPTH / 2]);
        send_op(CMD_PUSH, fresh_value());
        while (mirror_level > 0)
            send_op(CMD_POP, $urandom());
        send_op(CMD_POP, $urandom());
    endtask

    // Segments with a drifting push bias so the fill level sweeps between
    // empty and full; some segments run with no gaps at all
    task automatic test_random_mix(input int n_ops);
        int issued;
        int seg_len;
        int push_pct;
        issued = 0;
        while (issued < n_ops)
        begin
            seg_len      = $urandom_range(40, 120);
            push_pct     = 20 + 20 * $urandom_range(0, 3);
            sender_quiet = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < seg_len && issued < n_ops; i++)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    send_op(CMD_PUSH, push_candidate());
                else
                    send_op(CMD_POP, $urandom());
                issued++;
            end
        end
        sender_quiet = 1'b0;
    endtask

    // Result side stall: alternate runs of stall and flow, occasionally long
    initial
    begin : result_stall_gen
        int run;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 2) == 0)
            begin
                run = idle_len();
                if (run > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (run) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                              : $urandom_range(1, 12);
            repeat (run - 1) @(posedge clk);
        end
    end

    // Compare every accepted result transaction with the oldest expectation
    always @(posedge clk)
    begin
        stack_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d, popped_value %h", status, popped_value);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (popped_value !== want.popped)
                begin
                    $error("popped_value: expected %h, got %h", want.popped, popped_value);
                    fail_count++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    fail_count++;
                end
                if (is_empty !== want.empty)
                begin
                    $error("is_empty: expected %0b, got %0b", want.empty, is_empty);
                    fail_count++;
                end
                if (is_full !== want.full)
                begin
                    $error("is_full: expected %0b, got %0b", want.full, is_full);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #4000000;
        $display("[unique_entry_stack] ERROR");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes_and_duplicates();
        test_fill_to_full();
        test_random_mix(1150);
        in_valid <= 1'b0;

        // drain outstanding results, then allow for the result register
        for (int i = 0; i < 5000 && expected_results.size() != 0; i++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[unique_entry_stack] OK");
        else
            $display("[unique_entry_stack] ERROR");
        $finish;
    end

endmodule
